// ===== rtl/core/sha256_pkg.sv =====
// Shared constants, round constants and SHA-256 mixing functions.
`default_nettype none
package sha256_pkg;

    localparam int DataW      = 8;
    localparam int WordW      = 32;
    localparam int IdxW       = 3;
    localparam int CountW     = 61;
    localparam int BlockBytes = 64;
    localparam int BlockWords = 16;
    localparam int HashWords  = 8;
    localparam int Rounds     = 64;
    localparam int LenPos     = 56;
    localparam int PosW       = $clog2(BlockBytes);
    localparam int RoundW     = $clog2(Rounds);

    localparam logic [DataW-1:0] PadMark = 8'h80;

    localparam logic [WordW-1:0] InitHash [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WordW-1:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_ifs.sv =====
// Request and digest channel interfaces.
`default_nettype none
interface sha256_req_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [sha256_pkg::DataW-1:0]    data_byte;

    modport source (output valid, mode, data_byte, input ready);
    modport sink   (input valid, mode, data_byte, output ready);
endinterface

interface sha256_dig_if;
    logic                            valid;
    logic                            ready;
    logic [sha256_pkg::WordW-1:0]    digest_word;
    logic [sha256_pkg::IdxW-1:0]     word_index;
    logic                            last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sha256_hash_engine.sv =====
// Streaming SHA-256 engine: byte absorb, padding sequencer, iterative round unit.
//
//  channel  | dir | fields                                   | per request
//  ---------+-----+------------------------------------------+------------------------
//  i_req    | in  | mode, data_byte                          | absorb one byte / finish
//  o_dig    | out | digest_word, word_index, last_word       | eight words after finish
//
// An absorbed byte is taken while idle; the 64th byte of a block starts the rounds, then
// the working words are folded into the hash before the next byte is taken.
// The single round unit runs one round per cycle.
// Finish walks the pad bytes one at a time, runs one or two compressions, then
// holds each digest word until it is taken. Synchronous active-low reset restores
// the initial hash values and a zero byte count; no request is taken until idle.
`default_nettype none
module sha256_hash_engine (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sha256_req_if.sink       i_req,
    sha256_dig_if.source     o_dig
);

    localparam logic [sha256_pkg::PosW-1:0]   LastPos   = sha256_pkg::PosW'(sha256_pkg::BlockBytes - 1);
    localparam logic [sha256_pkg::PosW-1:0]   LenStart  = sha256_pkg::PosW'(sha256_pkg::LenPos);
    localparam logic [sha256_pkg::RoundW-1:0] LastRound = sha256_pkg::RoundW'(sha256_pkg::Rounds - 1);
    localparam logic [sha256_pkg::IdxW-1:0]   LastIdx   = sha256_pkg::IdxW'(sha256_pkg::HashWords - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PAD    = 5'b00010,
        S_ROUND  = 5'b00100,
        S_UPDATE = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    typedef logic [sha256_pkg::WordW-1:0] t_word;

    t_state                            r_state, n_state;
    t_word                             r_w    [sha256_pkg::BlockWords];
    t_word                             n_w    [sha256_pkg::BlockWords];
    t_word                             r_v    [sha256_pkg::HashWords];
    t_word                             n_v    [sha256_pkg::HashWords];
    t_word                             r_hash [sha256_pkg::HashWords];
    t_word                             n_hash [sha256_pkg::HashWords];
    logic [sha256_pkg::CountW-1:0]     r_count, n_count;
    logic [sha256_pkg::PosW-1:0]       r_pos, n_pos;
    logic [sha256_pkg::RoundW-1:0]     r_round, n_round;
    logic [sha256_pkg::IdxW-1:0]       r_idx, n_idx;
    logic                              r_first, n_first;     // next pad byte is the 0x80 mark
    logic                              r_extra, n_extra;     // length goes in a following block
    logic                              r_final, n_final;     // current compression ends the message
    logic                              r_padding, n_padding;

    logic                              req_acc;
    logic                              dig_acc;
    logic [2*sha256_pkg::WordW-1:0]    len_bits;
    logic [sha256_pkg::IdxW-1:0]       len_lane;
    logic [sha256_pkg::DataW-1:0]      len_byte;
    logic [sha256_pkg::DataW-1:0]      pad_byte;
    logic [sha256_pkg::DataW-1:0]      in_byte;
    t_word                             ch, maj, t1, t2, w_next;

    assign req_acc = i_req.valid && i_req.ready;
    assign dig_acc = o_dig.valid && o_dig.ready;

    // Length field: byte count times eight, sent most significant byte first.
    assign len_bits = {r_count, 3'b000};
    assign len_lane = ~r_pos[sha256_pkg::IdxW-1:0];
    assign len_byte = len_bits[{len_lane, 3'b000} +: sha256_pkg::DataW];

    always_comb begin
        if (r_first) begin
            pad_byte = sha256_pkg::PadMark;
        end else if (!r_extra && (r_pos >= LenStart)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = '0;
        end
    end

    assign in_byte = (r_state == S_PAD) ? pad_byte : i_req.data_byte;

    // Shared round unit and message schedule step.
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + sha256_pkg::big_sigma1(r_v[4]) + ch
               + sha256_pkg::RoundK[r_round] + r_w[0];
    assign t2  = sha256_pkg::big_sigma0(r_v[0]) + maj;
    assign w_next = sha256_pkg::small_sigma1(r_w[14]) + r_w[9]
                  + sha256_pkg::small_sigma0(r_w[1]) + r_w[0];

    always_comb begin
        n_state   = r_state;
        n_w       = r_w;
        n_v       = r_v;
        n_hash    = r_hash;
        n_count   = r_count;
        n_pos     = r_pos;
        n_round   = r_round;
        n_idx     = r_idx;
        n_first   = r_first;
        n_extra   = r_extra;
        n_final   = r_final;
        n_padding = r_padding;

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (!i_req.mode) begin
                        // Shift the byte into the block window, big-endian words.
                        for (int i = 0; i < sha256_pkg::BlockWords - 1; i++) begin
                            n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
                        end
                        n_w[sha256_pkg::BlockWords-1] =
                            {r_w[sha256_pkg::BlockWords-1][23:0], in_byte};
                        n_count = r_count + 1'b1;
                        n_pos   = r_pos + 1'b1;
                        if (r_pos == LastPos) begin
                            n_v     = r_hash;
                            n_round = '0;
                            n_final = 1'b0;
                            n_state = S_ROUND;
                        end
                    end else begin
                        n_first   = 1'b1;
                        n_extra   = (r_pos >= LenStart);
                        n_padding = 1'b1;
                        n_state   = S_PAD;
                    end
                end
            end
            S_PAD: begin
                for (int i = 0; i < sha256_pkg::BlockWords - 1; i++) begin
                    n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
                end
                n_w[sha256_pkg::BlockWords-1] =
                    {r_w[sha256_pkg::BlockWords-1][23:0], in_byte};
                n_first = 1'b0;
                n_pos   = r_pos + 1'b1;
                if (r_pos == LastPos) begin
                    n_v     = r_hash;
                    n_round = '0;
                    n_final = !r_extra;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                // Advance the schedule window: w[t+16] enters at the top.
                for (int i = 0; i < sha256_pkg::BlockWords - 1; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[sha256_pkg::BlockWords-1] = w_next;
                n_round = r_round + 1'b1;
                if (r_round == LastRound) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                for (int i = 0; i < sha256_pkg::HashWords; i++) begin
                    n_hash[i] = r_hash[i] + r_v[i];
                end
                n_extra = 1'b0;
                if (r_final) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else if (r_padding) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (dig_acc) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LastIdx) begin
                        // Drop back to a fresh message.
                        n_hash    = sha256_pkg::InitHash;
                        n_count   = '0;
                        n_pos     = '0;
                        n_final   = 1'b0;
                        n_padding = 1'b0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hash    <= sha256_pkg::InitHash;
            r_count   <= '0;
            r_pos     <= '0;
            r_round   <= '0;
            r_idx     <= '0;
            r_first   <= 1'b0;
            r_extra   <= 1'b0;
            r_final   <= 1'b0;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hash    <= n_hash;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_round   <= n_round;
            r_idx     <= n_idx;
            r_first   <= n_first;
            r_extra   <= n_extra;
            r_final   <= n_final;
            r_padding <= n_padding;
        end
    end

    // Block window and working words carry payload only.
    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_v <= n_v;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_dig.valid       = (r_state == S_EMIT);
    assign o_dig.digest_word = r_hash[r_idx];
    assign o_dig.word_index  = r_idx;
    assign o_dig.last_word   = (r_idx == LastIdx);

endmodule
`default_nettype wire

// ===== tb/sv/sha256_hash_engine_tb_pkg.sv =====
// Request mode codes and the digest beat type shared by the testbench files.
`timescale 1ns / 1ps
package sha256_hash_engine_tb_pkg;

    typedef enum logic {
        ModeAbsorb = 1'b0,
        ModeFinish = 1'b1
    } t_req_mode;

    typedef struct packed {
        logic [sha256_pkg::WordW-1:0] word;
        logic [sha256_pkg::IdxW-1:0]  idx;
        logic                         last;
    } t_digest_beat;

endpackage

// ===== tb/sv/sha256_hash_engine_checker.sv =====
// Digest predictor and scoreboard watching the request and digest channels.
`timescale 1ns / 1ps
module sha256_hash_engine_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    sha256_req_if i_req,
    sha256_dig_if i_dig,
    output int    o_fail_count,
    output int    o_pending
);

    localparam logic [31:0] IvWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] EndMark = 8'h80;

    logic [31:0]  hash_st [8];
    logic [7:0]   blk [64];
    logic [60:0]  msg_len;
    sha256_hash_engine_tb_pkg::t_digest_beat digest_due [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic void clear_message();
        for (int i = 0; i < 8; i++)
            hash_st[i] = IvWords[i];
        msg_len = '0;
    endfunction

    // Run the 64 rounds on blk and fold the result into hash_st.
    function automatic void fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = hash_st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_st[i] = hash_st[i] + v[i];
    endfunction

    // Absorb one byte, or pad, fold and queue the eight digest words.
    function automatic void track_request(input sha256_hash_engine_tb_pkg::t_req_mode mode,
                                          input logic [7:0] b);
        int          pos;
        logic [63:0] bit_len;
        sha256_hash_engine_tb_pkg::t_digest_beat beat;
        pos = int'(msg_len[5:0]);
        if (mode == sha256_hash_engine_tb_pkg::ModeAbsorb) begin
            blk[pos] = b;
            msg_len = msg_len + 1'b1;
            if (pos == 63)
                fold_block();
            return;
        end
        blk[pos] = EndMark;
        pos++;
        // no room left for the length field: close this block, open another
        if (pos > 56) begin
            for (int i = pos; i < 64; i++)
                blk[i] = '0;
            fold_block();
            pos = 0;
        end
        for (int i = pos; i < 56; i++)
            blk[i] = '0;
        bit_len = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++)
            blk[56+i] = bit_len[63-8*i -: 8];
        fold_block();
        for (int i = 0; i < 8; i++) begin
            beat.word = hash_st[i];
            beat.idx  = i[2:0];
            beat.last = (i == 7);
            digest_due.push_back(beat);
        end
        clear_message();
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        clear_message();
    end

    always @(posedge i_clk) begin : watch
        sha256_hash_engine_tb_pkg::t_digest_beat want;
        if (!i_rst_n) begin
            clear_message();
            digest_due.delete();
        end else begin
            // a word taken now cannot belong to a request taken at the same edge
            if (i_dig.valid && i_dig.ready) begin
                if (digest_due.size() == 0) begin
                    $error("unexpected digest word %h (index %0d)",
                           i_dig.digest_word, i_dig.word_index);
                    o_fail_count++;
                end else begin
                    want = digest_due.pop_front();
                    if (i_dig.digest_word !== want.word) begin
                        $error("digest_word: expected %h, got %h",
                               want.word, i_dig.digest_word);
                        o_fail_count++;
                    end
                    if (i_dig.word_index !== want.idx) begin
                        $error("word_index: expected %0d, got %0d",
                               want.idx, i_dig.word_index);
                        o_fail_count++;
                    end
                    if (i_dig.last_word !== want.last) begin
                        $error("last_word: expected %0b, got %0b",
                               want.last, i_dig.last_word);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                track_request(sha256_hash_engine_tb_pkg::t_req_mode'(i_req.mode),
                              i_req.data_byte);
        end
        o_pending = digest_due.size();
    end

endmodule

// ===== tb/sv/sha256_hash_engine_tb.sv =====
// Top of the SHA-256 engine testbench: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps
module sha256_hash_engine_tb;

    // Generous bound: a slow run with full stalls stays far below this.
    localparam int LimitCycles = 200000;
    // Quiet time after the last digest word, covers a full finish with two blocks.
    localparam int DrainCycles = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic calm = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   stall_left = 0;

    sha256_req_if req_ch ();
    sha256_dig_if dig_ch ();

    sha256_hash_engine dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_dig   (dig_ch)
    );

    sha256_hash_engine_checker scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_dig        (dig_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: end the run if the engine hangs.
    always @(posedge clk) begin
        cycles++;
        if (cycles > LimitCycles) begin
            $display("sha256_hash_engine verification failed");
            $finish;
        end
    end

    // Digest side back-pressure: drop ready in random bursts, hold it high once calm.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            dig_ch.ready = 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            dig_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
        end else begin
            dig_ch.ready = 1'b1;
        end
    end

    // Drive one request at the falling edge and hold it until the engine takes it.
    // Now and then idle the channel for a burst first.
    task automatic send_req(input sha256_hash_engine_tb_pkg::t_req_mode mode,
                            input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid     = 1'b1;
        req_ch.mode      = mode;
        req_ch.data_byte = b;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    initial begin : stimulus
        int rand_items;
        int rand_digests;
        int msg_idx;
        int len;
        req_ch.valid     = 1'b0;
        req_ch.mode      = sha256_hash_engine_tb_pkg::ModeAbsorb;
        req_ch.data_byte = '0;
        rand_items   = 0;
        rand_digests = 0;
        msg_idx      = 0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Empty message straight out of reset.
        send_req(sha256_hash_engine_tb_pkg::ModeFinish, 8'h00);
        // "abc"; the finish carries a byte that must be ignored.
        send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'h61);
        send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'h62);
        send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'h63);
        send_req(sha256_hash_engine_tb_pkg::ModeFinish, 8'hff);
        // Byte extremes and alternating bit patterns.
        send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'h00);
        send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'hff);
        send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'h55);
        send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'haa);
        send_req(sha256_hash_engine_tb_pkg::ModeFinish, 8'h5a);
        // Finish right after a finish: the state must be back to an empty message.
        send_req(sha256_hash_engine_tb_pkg::ModeFinish, 8'h00);

        // Hold the request channel until every digest word is out.
        @(negedge clk);
        req_ch.valid = 1'b0;
        wait_drained();

        // Random messages. The first two sit on either side of the point where
        // the length no longer fits and padding needs an extra block; later ones
        // are mostly short, with an occasional block-boundary length.
        while (rand_items < 119 || rand_digests < 6) begin
            if (msg_idx == 0)
                len = 55;
            else if (msg_idx == 1)
                len = 56;
            else if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0:       len = 57;
                    1:       len = 63;
                    2:       len = 64;
                    default: len = 65;
                endcase
            end else
                len = $urandom_range(0, 9);
            for (int k = 0; k < len; k++)
                send_req(sha256_hash_engine_tb_pkg::ModeAbsorb, 8'($urandom));
            send_req(sha256_hash_engine_tb_pkg::ModeFinish, 8'($urandom));
            rand_items += len + 1;
            rand_digests++;
            msg_idx++;
            // Run the tail of the stimulus with no idling on either side.
            if (rand_items >= 95)
                calm = 1'b1;
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        wait_drained();
        // Give stray digest words time to show up.
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0)
            $display("sha256_hash_engine verification clean");
        else
            $display("sha256_hash_engine verification failed");
        $finish;
    end

endmodule
